### hw/rtl/sipc_pkg.sv
// Shared types, constants and the method-word matcher for the SIP packet classifier.
// Depends on nothing; imported by sip_packet_classifier, its checker and the testbench.
package sipc_pkg;

    localparam int PREFIX_DEPTH = 9;
    localparam int PREFIX_IDX_W = $clog2(PREFIX_DEPTH);
    localparam int NUM_METHODS  = 13;
    localparam int WORD_W       = PREFIX_DEPTH * 8;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 136;
    localparam int OUT_USER_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [15:0] SIP_PORT_FIRST_RESET  = 16'd5060;
    localparam logic [15:0] SIP_PORT_SECOND_RESET = 16'd5061;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [3:0] IP_VERSION_4 = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORT_FIRST  = 1'b0,
        CFG_PORT_SECOND = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_SIP        = 3'd0,
        ST_NOT_IPV4   = 3'd1,
        ST_BAD_IP     = 3'd2,
        ST_NOT_L4     = 3'd3,
        ST_BAD_L4     = 3'd4,
        ST_EMPTY      = 3'd5,
        ST_PORT       = 3'd6,
        ST_NO_METHOD  = 3'd7
    } status_t;

    typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

    // First character of each word sits in the top byte.
    localparam logic [WORD_W-1:0] METHOD_WORD [NUM_METHODS] = '{
        {"SIP/2.0",   16'h0},
        {"INVITE ",   16'h0},
        {"BYE ",      40'h0},
        {"ACK ",      40'h0},
        {"REGISTER",  8'h0},
        {"OPTIONS ",  8'h0},
        {"CANCEL ",   16'h0},
        {"NOTIFY ",   16'h0},
        {"SUBSCRIBE"},
        {"INFO ",     32'h0},
        {"REFER ",    24'h0},
        {"UPDATE ",   16'h0},
        {"PRACK ",    24'h0}
    };

    localparam logic [3:0] METHOD_CMP_LEN [NUM_METHODS] = '{
        4'd7, 4'd7, 4'd4, 4'd4, 4'd8, 4'd8, 4'd7, 4'd7, 4'd9, 4'd5, 4'd6, 4'd7, 4'd6
    };

    localparam logic [3:0] METHOD_MIN_LEN [NUM_METHODS] = '{
        4'd7, 4'd7, 4'd7, 4'd7, 4'd9, 4'd8, 4'd7, 4'd7, 4'd10, 4'd7, 4'd7, 4'd7, 4'd7
    };

    // True when the payload starts with a known word and is long enough for it.
    function automatic logic method_match(input prefix_t pre, input logic [15:0] plen);
        logic hit;
        logic eq;
        hit = 1'b0;
        for (int i = 0; i < NUM_METHODS; i++)
        begin
            eq = 1'b1;
            for (int k = 0; k < PREFIX_DEPTH; k++)
            begin
                if ((4'(k) < METHOD_CMP_LEN[i]) &&
                    (pre[k] != METHOD_WORD[i][(PREFIX_DEPTH-1-k)*8 +: 8]))
                begin
                    eq = 1'b0;
                end
            end
            if (eq && (plen >= {12'd0, METHOD_MIN_LEN[i]}))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### hw/rtl/sip_packet_classifier.sv
// m_tvalid rises once the tlast beat's result has passed the snapshot and output registers.
// Throughput: one packet byte per cycle; s_tready falls only while the snapshot
// register and the output register both hold results and m_tready is low.
// Reset (rst_n, asynchronous, active low): parser state clears to zero, the SIP
// ports return to 5060 and 5061, and no result is pending.
// Header parser, snapshot stage and classifier for IPv4 UDP/TCP SIP packets.
// Depends on sipc_pkg.
module sip_packet_classifier
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sipc_pkg::IN_DATA_W-1:0]   s_tdata,   // packet_byte
    input  logic                             s_tlast,   // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // l4_protocol, source_address, destination_address, source_port,
    // destination_port, payload_offset, payload_length
    output logic [sipc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [sipc_pkg::OUT_USER_W-1:0]  m_tuser,   // status, is_sip
    input  logic                             cfg_wr_en,
    input  logic [sipc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sipc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sipc_pkg::*;

    // Configuration
    logic [15:0] port_first_reg;
    logic [15:0] port_second_reg;

    // Live per-packet state
    logic [15:0] byte_index_reg,  byte_index_next;
    logic [7:0]  vihl_reg,        vihl_next;
    logic [15:0] total_len_reg,   total_len_next;
    logic [7:0]  proto_reg,       proto_next;
    logic [31:0] src_addr_reg,    src_addr_next;
    logic [31:0] dst_addr_reg,    dst_addr_next;
    logic [15:0] sport_reg,       sport_next;
    logic [15:0] dport_reg,       dport_next;
    logic [15:0] udp_len_reg,     udp_len_next;
    logic [5:0]  tcp_hdr_reg,     tcp_hdr_next;
    prefix_t     prefix_reg,      prefix_next;

    // Values after the current byte, before the end-of-packet clear
    logic [15:0] upd_total_len;
    logic [7:0]  upd_vihl;
    logic [7:0]  upd_proto;
    logic [31:0] upd_src_addr;
    logic [31:0] upd_dst_addr;
    logic [15:0] upd_sport;
    logic [15:0] upd_dport;
    logic [15:0] upd_udp_len;
    logic [5:0]  upd_tcp_hdr;
    prefix_t     upd_prefix;
    logic [15:0] upd_present;

    logic [5:0]  cur_ihl;
    logic [15:0] rel;
    logic [6:0]  poff;
    logic        poff_ok;
    logic [15:0] pdiff;

    // Snapshot of a finished packet
    logic        snap_valid_reg;
    logic [15:0] snap_present_reg;
    logic [7:0]  snap_vihl_reg;
    logic [15:0] snap_total_len_reg;
    logic [7:0]  snap_proto_reg;
    logic [31:0] snap_src_addr_reg;
    logic [31:0] snap_dst_addr_reg;
    logic [15:0] snap_sport_reg;
    logic [15:0] snap_dport_reg;
    logic [15:0] snap_udp_len_reg;
    logic [5:0]  snap_tcp_hdr_reg;
    prefix_t     snap_prefix_reg;

    // Classifier
    logic [15:0] c_ihl;
    logic [15:0] c_tcp;
    logic [15:0] c_span;
    logic [15:0] c_l4len;
    logic [15:0] c_udp_pay;
    logic [15:0] c_l4_pay;
    logic [15:0] c_plen;
    logic [15:0] c_off;
    logic        c_good;
    status_t     c_status;
    logic        c_port_hit;

    // Output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [7:0]  out_proto_reg;
    logic [31:0] out_src_addr_reg;
    logic [31:0] out_dst_addr_reg;
    logic [15:0] out_sport_reg;
    logic [15:0] out_dport_reg;
    logic [15:0] out_off_reg;
    logic [15:0] out_plen_reg;

    logic in_beat;
    logic out_load;

    // The output register frees up in the same cycle its beat is taken.
    assign s_tready = !(snap_valid_reg && out_valid_reg) || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign out_load = snap_valid_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_first_reg  <= SIP_PORT_FIRST_RESET;
            port_second_reg <= SIP_PORT_SECOND_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PORT_FIRST:  port_first_reg  <= cfg_data;
                CFG_PORT_SECOND: port_second_reg <= cfg_data;
                default:         port_first_reg  <= port_first_reg;
            endcase
        end
    end

    // Header field capture for one byte
    always_comb
    begin
        cur_ihl       = {vihl_reg[3:0], 2'b00};
        upd_vihl      = vihl_reg;
        upd_total_len = total_len_reg;
        upd_proto     = proto_reg;
        upd_src_addr  = src_addr_reg;
        upd_dst_addr  = dst_addr_reg;
        upd_sport     = sport_reg;
        upd_dport     = dport_reg;
        upd_udp_len   = udp_len_reg;
        upd_tcp_hdr   = tcp_hdr_reg;
        upd_prefix    = prefix_reg;
        rel           = byte_index_reg - {10'd0, cur_ihl};
        poff          = '0;
        poff_ok       = 1'b0;
        pdiff         = '0;

        priority if (byte_index_reg == 16'd0)
            upd_vihl = s_tdata;
        else if (byte_index_reg == 16'd2)
            upd_total_len[15:8] = s_tdata;
        else if (byte_index_reg == 16'd3)
            upd_total_len[7:0] = s_tdata;
        else if (byte_index_reg == 16'd9)
            upd_proto = s_tdata;
        else if (byte_index_reg >= 16'd12 && byte_index_reg <= 16'd15)
            upd_src_addr = {src_addr_reg[23:0], s_tdata};
        else if (byte_index_reg >= 16'd16 && byte_index_reg <= 16'd19)
            upd_dst_addr = {dst_addr_reg[23:0], s_tdata};
        else
            upd_vihl = vihl_reg;

        if (byte_index_reg != 16'd0 && cur_ihl >= 6'd20 &&
            byte_index_reg >= {10'd0, cur_ihl})
        begin
            priority if (rel <= 16'd1)
                upd_sport = {sport_reg[7:0], s_tdata};
            else if (rel <= 16'd3)
                upd_dport = {dport_reg[7:0], s_tdata};
            else if (rel <= 16'd5)
                upd_udp_len = {udp_len_reg[7:0], s_tdata};
            else if (rel == 16'd12)
                upd_tcp_hdr = {s_tdata[7:4], 2'b00};
            else
                upd_tcp_hdr = tcp_hdr_reg;

            // The TCP offset uses the header length taken from this very byte.
            if (proto_reg == PROTO_UDP)
            begin
                poff    = {1'b0, cur_ihl} + 7'd8;
                poff_ok = 1'b1;
            end
            else if (proto_reg == PROTO_TCP && upd_tcp_hdr != 6'd0)
            begin
                poff    = {1'b0, cur_ihl} + {1'b0, upd_tcp_hdr};
                poff_ok = 1'b1;
            end

            pdiff = byte_index_reg - {9'd0, poff};
            if (poff_ok && byte_index_reg >= {9'd0, poff} &&
                pdiff < 16'(PREFIX_DEPTH))
            begin
                upd_prefix[pdiff[PREFIX_IDX_W-1:0]] = s_tdata;
            end
        end

        upd_present = (byte_index_reg == 16'hFFFF) ? byte_index_reg : byte_index_reg + 16'd1;
    end

    // A finished packet leaves the live state cleared for the next one.
    always_comb
    begin
        byte_index_next = byte_index_reg;
        vihl_next       = vihl_reg;
        total_len_next  = total_len_reg;
        proto_next      = proto_reg;
        src_addr_next   = src_addr_reg;
        dst_addr_next   = dst_addr_reg;
        sport_next      = sport_reg;
        dport_next      = dport_reg;
        udp_len_next    = udp_len_reg;
        tcp_hdr_next    = tcp_hdr_reg;
        prefix_next     = prefix_reg;
        if (in_beat)
        begin
            if (s_tlast)
            begin
                byte_index_next = '0;
                vihl_next       = '0;
                total_len_next  = '0;
                proto_next      = '0;
                src_addr_next   = '0;
                dst_addr_next   = '0;
                sport_next      = '0;
                dport_next      = '0;
                udp_len_next    = '0;
                tcp_hdr_next    = '0;
                prefix_next     = '0;
            end
            else
            begin
                byte_index_next = upd_present;
                vihl_next       = upd_vihl;
                total_len_next  = upd_total_len;
                proto_next      = upd_proto;
                src_addr_next   = upd_src_addr;
                dst_addr_next   = upd_dst_addr;
                sport_next      = upd_sport;
                dport_next      = upd_dport;
                udp_len_next    = upd_udp_len;
                tcp_hdr_next    = upd_tcp_hdr;
                prefix_next     = upd_prefix;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            vihl_reg       <= '0;
            total_len_reg  <= '0;
            proto_reg      <= '0;
            src_addr_reg   <= '0;
            dst_addr_reg   <= '0;
            sport_reg      <= '0;
            dport_reg      <= '0;
            udp_len_reg    <= '0;
            tcp_hdr_reg    <= '0;
            prefix_reg     <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            vihl_reg       <= vihl_next;
            total_len_reg  <= total_len_next;
            proto_reg      <= proto_next;
            src_addr_reg   <= src_addr_next;
            dst_addr_reg   <= dst_addr_next;
            sport_reg      <= sport_next;
            dport_reg      <= dport_next;
            udp_len_reg    <= udp_len_next;
            tcp_hdr_reg    <= tcp_hdr_next;
            prefix_reg     <= prefix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (in_beat && s_tlast)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && s_tlast)
        begin
            snap_present_reg   <= upd_present;
            snap_vihl_reg      <= upd_vihl;
            snap_total_len_reg <= upd_total_len;
            snap_proto_reg     <= upd_proto;
            snap_src_addr_reg  <= upd_src_addr;
            snap_dst_addr_reg  <= upd_dst_addr;
            snap_sport_reg     <= upd_sport;
            snap_dport_reg     <= upd_dport;
            snap_udp_len_reg   <= upd_udp_len;
            snap_tcp_hdr_reg   <= upd_tcp_hdr;
            snap_prefix_reg    <= upd_prefix;
        end
    end

    // Classification of the snapshot
    always_comb
    begin
        c_ihl      = {10'd0, snap_vihl_reg[3:0], 2'b00};
        c_tcp      = {10'd0, snap_tcp_hdr_reg};
        c_span     = (snap_present_reg < snap_total_len_reg) ?
                     snap_present_reg : snap_total_len_reg;
        c_l4len    = c_span - c_ihl;
        c_udp_pay  = snap_udp_len_reg - 16'd8;
        c_l4_pay   = c_l4len - 16'd8;
        c_plen     = '0;
        c_off      = '0;
        c_good     = 1'b0;
        c_status   = ST_SIP;
        c_port_hit = (snap_sport_reg == port_first_reg) ||
                     (snap_sport_reg == port_second_reg) ||
                     (snap_dport_reg == port_first_reg) ||
                     (snap_dport_reg == port_second_reg);

        priority if (snap_vihl_reg[7:4] != IP_VERSION_4)
            c_status = ST_NOT_IPV4;
        else if (c_ihl > snap_total_len_reg || c_ihl < 16'd20)
            c_status = ST_BAD_IP;
        else if (c_span < c_ihl)
            c_status = ST_BAD_IP;
        else if (snap_proto_reg == PROTO_UDP)
        begin
            if (c_l4len < 16'd8 || snap_udp_len_reg < 16'd8)
                c_status = ST_BAD_L4;
            else
            begin
                c_plen = (c_udp_pay < c_l4_pay) ? c_udp_pay : c_l4_pay;
                c_off  = c_ihl + 16'd8;
                c_good = 1'b1;
            end
        end
        else if (snap_proto_reg == PROTO_TCP)
        begin
            if (c_l4len < 16'd20 || c_tcp < 16'd20 || c_tcp > c_l4len)
                c_status = ST_BAD_L4;
            else
            begin
                c_plen = c_l4len - c_tcp;
                c_off  = c_ihl + c_tcp;
                c_good = 1'b1;
            end
        end
        else
            c_status = ST_NOT_L4;

        if (c_good)
        begin
            priority if (c_plen == 16'd0)
                c_status = ST_EMPTY;
            else if (!c_port_hit)
                c_status = ST_PORT;
            else if (!method_match(snap_prefix_reg, c_plen))
                c_status = ST_NO_METHOD;
            else
                c_status = ST_SIP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg   <= c_status;
            out_proto_reg    <= snap_proto_reg;
            out_src_addr_reg <= snap_src_addr_reg;
            out_dst_addr_reg <= snap_dst_addr_reg;
            out_sport_reg    <= c_good ? snap_sport_reg : 16'd0;
            out_dport_reg    <= c_good ? snap_dport_reg : 16'd0;
            out_off_reg      <= c_off;
            out_plen_reg     <= c_plen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_plen_reg, out_off_reg, out_dport_reg, out_sport_reg,
                       out_dst_addr_reg, out_src_addr_reg, out_proto_reg};
    assign m_tuser  = {(out_status_reg == ST_SIP), out_status_reg};

endmodule

### hw/rtl/sipc_checker.sv
// Port-level checker for the SIP packet classifier and its bind statement.
// Depends on sipc_pkg and on the port list of sip_packet_classifier.
module sipc_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sipc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [sipc_pkg::OUT_USER_W-1:0]  m_tuser
);
    import sipc_pkg::*;

    // A stalled result beat must hold its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

    // The input side can only be held off by a result that is not being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled although the result side is free");

    // The SIP flag agrees with the status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[3] == (m_tuser[2:0] == ST_SIP)))
    else $error("is_sip disagrees with status");

    // Header failures report no ports, offset or length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] == ST_NOT_IPV4 || m_tuser[2:0] == ST_BAD_IP ||
                     m_tuser[2:0] == ST_NOT_L4 || m_tuser[2:0] == ST_BAD_L4)
        |-> m_tdata[135:72] == '0)
    else $error("transport fields set on a header failure");

    // A SIP packet is UDP or TCP with a non-empty payload past the IP header.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:0] == ST_SIP
        |-> (m_tdata[7:0] == PROTO_UDP || m_tdata[7:0] == PROTO_TCP) &&
            m_tdata[135:120] != 16'd0 && m_tdata[119:104] >= 16'd28)
    else $error("SIP result with impossible transport fields");

endmodule

bind sip_packet_classifier sipc_checker u_sipc_checker (.*);

### tb/sv/sip_packet_classifier_test.sv
// Self-checking testbench for sip_packet_classifier: streams IPv4 packets a byte per beat,
// predicts each packet's verdict in a scoreboard class and checks every result beat.
// Depends on sipc_pkg and the sip_packet_classifier RTL.
module sip_packet_classifier_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sipc_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        status_t     status;
        logic        is_sip;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [15:0] pay_off;
        logic [15:0] pay_len;
    } sip_verdict_t;

    class sip_verdict_board;
        logic [15:0]  port_first;
        logic [15:0]  port_second;
        int           byte_pos;
        logic [7:0]   ver_ihl;
        logic [15:0]  ip_len;
        logic [7:0]   ip_proto;
        logic [31:0]  src_addr;
        logic [31:0]  dst_addr;
        logic [15:0]  l4_sport;
        logic [15:0]  l4_dport;
        logic [15:0]  udp_len;
        logic [7:0]   tcp_hdr_len;
        logic [7:0]   head_bytes [9];
        string        words [13];
        int           cmp_len [13];
        int           min_len [13];
        sip_verdict_t pending_verdicts [$];
        int           mismatches;
        int           results_seen;

        function new();
            words   = '{"SIP/2.0", "INVITE ", "BYE ", "ACK ", "REGISTER", "OPTIONS ",
                        "CANCEL ", "NOTIFY ", "SUBSCRIBE", "INFO ", "REFER ", "UPDATE ",
                        "PRACK "};
            cmp_len = '{7, 7, 4, 4, 8, 8, 7, 7, 9, 5, 6, 7, 6};
            min_len = '{7, 7, 7, 7, 9, 8, 7, 7, 10, 7, 7, 7, 7};
            port_first   = SIP_PORT_FIRST_RESET;
            port_second  = SIP_PORT_SECOND_RESET;
            mismatches   = 0;
            results_seen = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_pos    = 0;
            ver_ihl     = '0;
            ip_len      = '0;
            ip_proto    = '0;
            src_addr    = '0;
            dst_addr    = '0;
            l4_sport    = '0;
            l4_dport    = '0;
            udp_len     = '0;
            tcp_hdr_len = '0;
            foreach (head_bytes[k])
            begin
                head_bytes[k] = '0;
            end
        endfunction

        function void set_port(cfg_index_t which, logic [15:0] value);
            if (which == CFG_PORT_FIRST)
            begin
                port_first = value;
            end
            else
            begin
                port_second = value;
            end
        endfunction

        function bit port_listed(logic [15:0] p);
            return (p == port_first) || (p == port_second);
        endfunction

        // Advances the parser by one accepted beat; a beat with tlast queues a verdict.
        function void take_byte(logic [7:0] b, logic last);
            int           idx;
            int           ihl;
            int           rel;
            int           poff;
            int           present;
            int           span;
            int           l4len;
            int           plen;
            int           off;
            bit           good;
            bit           found;
            bit           eq;
            sip_verdict_t v;

            idx = byte_pos;
            ihl = int'(ver_ihl[3:0]) * 4;

            if (idx == 0)
                ver_ihl = b;
            else if (idx == 2)
                ip_len[15:8] = b;
            else if (idx == 3)
                ip_len[7:0] = b;
            else if (idx == 9)
                ip_proto = b;
            else if (idx >= 12 && idx <= 15)
                src_addr = {src_addr[23:0], b};
            else if (idx >= 16 && idx <= 19)
                dst_addr = {dst_addr[23:0], b};

            if (idx > 0 && ihl >= 20 && idx >= ihl)
            begin
                rel  = idx - ihl;
                poff = 0;
                if (rel <= 1)
                    l4_sport = {l4_sport[7:0], b};
                else if (rel <= 3)
                    l4_dport = {l4_dport[7:0], b};
                else if (rel <= 5)
                    udp_len = {udp_len[7:0], b};
                else if (rel == 12)
                    tcp_hdr_len = {2'b00, b[7:4], 2'b00};

                if (ip_proto == PROTO_UDP)
                    poff = ihl + 8;
                else if (ip_proto == PROTO_TCP && tcp_hdr_len != 0)
                    poff = ihl + int'(tcp_hdr_len);
                if (poff != 0 && idx >= poff && idx - poff < 9)
                    head_bytes[idx - poff] = b;
            end

            if (idx < 65535)
                byte_pos = idx + 1;

            if (!last)
                return;

            ihl     = int'(ver_ihl[3:0]) * 4;
            present = (idx + 1 > 65535) ? 65535 : idx + 1;
            good    = 1'b0;
            plen    = 0;
            off     = 0;

            if (ver_ihl[7:4] != IP_VERSION_4)
            begin
                v.status = ST_NOT_IPV4;
            end
            else if (ihl > int'(ip_len) || ihl < 20)
            begin
                v.status = ST_BAD_IP;
            end
            else
            begin
                span = (present < int'(ip_len)) ? present : int'(ip_len);
                if (span < ihl)
                begin
                    v.status = ST_BAD_IP;
                end
                else
                begin
                    l4len = span - ihl;
                    if (ip_proto == PROTO_UDP)
                    begin
                        if (l4len < 8 || udp_len < 8)
                        begin
                            v.status = ST_BAD_L4;
                        end
                        else
                        begin
                            plen = int'(udp_len) - 8;
                            if (l4len - 8 < plen)
                                plen = l4len - 8;
                            off  = ihl + 8;
                            good = 1'b1;
                        end
                    end
                    else if (ip_proto == PROTO_TCP)
                    begin
                        if (l4len < 20 || tcp_hdr_len < 20 || int'(tcp_hdr_len) > l4len)
                        begin
                            v.status = ST_BAD_L4;
                        end
                        else
                        begin
                            plen = l4len - int'(tcp_hdr_len);
                            off  = ihl + int'(tcp_hdr_len);
                            good = 1'b1;
                        end
                    end
                    else
                    begin
                        v.status = ST_NOT_L4;
                    end
                end
            end

            if (good)
            begin
                found = 1'b0;
                for (int i = 0; i < 13; i++)
                begin
                    eq = 1'b1;
                    for (int k = 0; k < cmp_len[i]; k++)
                    begin
                        if (head_bytes[k] != 8'(words[i][k]))
                            eq = 1'b0;
                    end
                    if (eq && plen >= min_len[i])
                        found = 1'b1;
                end
                if (plen == 0)
                    v.status = ST_EMPTY;
                else if (!port_listed(l4_sport) && !port_listed(l4_dport))
                    v.status = ST_PORT;
                else if (!found)
                    v.status = ST_NO_METHOD;
                else
                    v.status = ST_SIP;
            end

            v.is_sip   = (v.status == ST_SIP);
            v.proto    = ip_proto;
            v.src_addr = src_addr;
            v.dst_addr = dst_addr;
            v.l4_sport = good ? l4_sport : 16'd0;
            v.l4_dport = good ? l4_dport : 16'd0;
            v.pay_off  = good ? 16'(off) : 16'd0;
            v.pay_len  = good ? 16'(plen) : 16'd0;
            pending_verdicts.push_back(v);
            clear_packet();
        endfunction

        function void compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: %s expected %0h, got %0h",
                             results_seen, name, want, got);
            end
        endfunction

        function void match_verdict(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            sip_verdict_t v;
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d arrived with no packet outstanding: user %0h",
                             results_seen, user);
                return;
            end
            v = pending_verdicts.pop_front();
            compare_field("status", 32'(user[2:0]), 32'(v.status));
            compare_field("is_sip", 32'(user[3]), 32'(v.is_sip));
            compare_field("l4_protocol", 32'(data[7:0]), 32'(v.proto));
            compare_field("source_address", data[39:8], v.src_addr);
            compare_field("destination_address", data[71:40], v.dst_addr);
            compare_field("source_port", 32'(data[87:72]), 32'(v.l4_sport));
            compare_field("destination_port", 32'(data[103:88]), 32'(v.l4_dport));
            compare_field("payload_offset", 32'(data[119:104]), 32'(v.pay_off));
            compare_field("payload_length", 32'(data[135:120]), 32'(v.pay_len));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // packet_byte
    logic                  s_tlast;     // last_byte
    logic                  m_tvalid;
    logic                  m_tready;
    // l4_protocol, source_address, destination_address, source_port,
    // destination_port, payload_offset, payload_length
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;     // status, is_sip
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sip_verdict_board board;
    logic [7:0]       frame_bytes [$];
    int               bytes_sent = 0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    bit               hold_request = 1'b0;
    int unsigned      cycle_count = 0;

    sip_packet_classifier u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL sip_packet_classifier");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.match_verdict(m_tdata, m_tuser);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] any_port(logic [15:0] p1, logic [15:0] p2);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return p1;
        if (r < 6)
            return p2;
        return 16'($urandom);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request so the block backs up.
    initial
    begin
        int gap_left;
        m_tready = 1'b0;
        gap_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap_left     = HOLD_CYCLES;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else if (rx_stall_pct > 0 && $urandom_range(1, 100) <= rx_stall_pct)
            begin
                gap_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Entered and left at a falling edge at which no sender input has been assigned yet.
    task automatic push_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = (tx_idle_pct > 0 && $urandom_range(1, 100) <= tx_idle_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        board.take_byte(value, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Builds an IPv4 packet with a UDP or TCP header and sends it. The length fields
    // can be skewed, bytes appended past the total length, or the tail cut off.
    task automatic send_ip(input logic [3:0] version, input logic [3:0] ihl_w,
                           input logic [7:0] proto, input logic [15:0] sport,
                           input logic [15:0] dport, input logic [3:0] tcp_w,
                           input string word, input int plen, input int tot_adj,
                           input int ulen_adj, input int trail, input int cut);
        int          hdr_len;
        int          l4_len;
        int          total;
        logic [15:0] tot16;
        logic [15:0] ulen;
        hdr_len = (ihl_w < 5) ? 20 : int'(ihl_w) * 4;
        l4_len  = (proto == PROTO_TCP) ? ((tcp_w < 5) ? 20 : int'(tcp_w) * 4) : 8;
        total   = hdr_len + l4_len + plen + tot_adj;
        if (total < 0)
            total = 0;
        if (total > 65535)
            total = 65535;
        tot16 = 16'(total);
        ulen  = 16'(8 + plen + ulen_adj);

        frame_bytes.delete();
        repeat (hdr_len + l4_len) frame_bytes.push_back(8'($urandom));
        frame_bytes[0] = {version, ihl_w};
        frame_bytes[2] = tot16[15:8];
        frame_bytes[3] = tot16[7:0];
        frame_bytes[9] = proto;
        frame_bytes[hdr_len]     = sport[15:8];
        frame_bytes[hdr_len + 1] = sport[7:0];
        frame_bytes[hdr_len + 2] = dport[15:8];
        frame_bytes[hdr_len + 3] = dport[7:0];
        if (proto == PROTO_TCP)
        begin
            frame_bytes[hdr_len + 12] = {tcp_w, 4'($urandom)};
        end
        else
        begin
            frame_bytes[hdr_len + 4] = ulen[15:8];
            frame_bytes[hdr_len + 5] = ulen[7:0];
        end
        for (int i = 0; i < plen; i++)
        begin
            frame_bytes.push_back((i < word.len()) ? 8'(word[i]) : 8'($urandom));
        end
        repeat (trail) frame_bytes.push_back(8'($urandom));
        repeat (cut)
        begin
            if (frame_bytes.size() > 1)
                void'(frame_bytes.pop_back());
        end
        send_frame();
    endtask

    task automatic write_port(input cfg_index_t which, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.set_port(which, value);
        @(negedge clk);
    endtask

    // Every packet yields a result, so an empty queue plus the pipeline depth means idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_phase(input int byte_budget, input logic [15:0] p1,
                                input logic [15:0] p2);
        int          start_bytes;
        int          packets;
        int          pick;
        int          r;
        int          plen;
        string       w;
        logic [7:0]  proto;
        start_bytes = bytes_sent;
        packets     = 0;
        while (bytes_sent - start_bytes < byte_budget || packets < 3)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
                send_frame();
            end
            else
            begin
                w = board.words[$urandom_range(0, 12)];
                if ($urandom_range(0, 9) < 2)
                    w.putc($urandom_range(0, w.len() - 1), 8'($urandom_range(65, 90)));
                if ($urandom_range(0, 9) < 8)
                    plen = w.len() + $urandom_range(0, 10);
                else
                    plen = $urandom_range(0, 10);
                r = $urandom_range(0, 19);
                proto = (r < 9) ? PROTO_UDP : (r < 18) ? PROTO_TCP : 8'($urandom);
                send_ip((pick < 11) ? 4'($urandom) : IP_VERSION_4,
                        ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 7)),
                        proto, any_port(p1, p2), any_port(p1, p2),
                        ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8)),
                        w, plen,
                        ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 16)) - 8 : 0,
                        ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 20)) - 10 : 0,
                        ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 6)) : 0,
                        ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 30)) : 0);
            end
            packets++;
        end
    endtask

    initial
    begin
        logic [15:0] pa;
        logic [15:0] pb;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_PORT_FIRST;
        cfg_data  = '0;
        board     = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed packets at the reset ports: each method word at its shortest legal length.
        for (int i = 0; i < 13; i++)
        begin
            send_ip(IP_VERSION_4, 4'd5, (i % 2 == 1) ? PROTO_TCP : PROTO_UDP,
                    16'(1000 + i), 16'd5060, 4'd5, board.words[i], board.min_len[i],
                    0, 0, 0, 0);
        end
        // One byte short of the length rule.
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd5061, 16'd9, 4'd5, "BYE ", 6, 0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd6, PROTO_TCP, 16'd5060, 16'd9, 4'd8, "REGISTER", 8,
                0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd7, 16'd5061, 4'd5, "SUBSCRIBE", 9,
                0, 0, 0, 0);
        // Header faults.
        send_ip(4'd6, 4'd5, PROTO_UDP, 16'd5060, 16'd5060, 4'd5, "INVITE ", 12, 0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd4, PROTO_UDP, 16'd5060, 16'd5060, 4'd5, "INVITE ", 12,
                0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd15, PROTO_UDP, 16'd5060, 16'd5060, 4'd5, "", 0, -28, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd15, PROTO_UDP, 16'd5060, 16'd5060, 4'd5, "INVITE ", 10,
                0, 0, 0, 48);
        send_ip(IP_VERSION_4, 4'd5, 8'd1, 16'd5060, 16'd5060, 4'd5, "INVITE ", 10, 0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd5060, 16'd5060, 4'd5, "", 0, 0, 0, 0, 3);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd5060, 16'd5060, 4'd5, "INVITE ", 5,
                0, -10, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_TCP, 16'd5060, 16'd5060, 4'd4, "SIP/2.0", 10,
                0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_TCP, 16'd5060, 16'd5060, 4'd15, "", 0, 0, 0, 0, 30);
        // Payload faults and length trimming.
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd5060, 16'd5060, 4'd5, "", 0, 0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd1234, 16'd80, 4'd5, "INVITE ", 20,
                0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd5060, 16'd5060, 4'd5, "HELLO W", 12,
                0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd5060, 16'd1, 4'd5, "INVITE ", 10,
                -3, 0, 10, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd2, 16'd5061, 4'd5, "ACK ", 12, 0, -4, 0, 0);
        // Buffers too short to hold the header at all.
        frame_bytes.delete();
        frame_bytes.push_back(8'h45);
        send_frame();
        frame_bytes.delete();
        repeat (5) frame_bytes.push_back(8'($urandom));
        frame_bytes[0] = 8'h45;
        send_frame();
        settle();

        write_port(CFG_PORT_FIRST, 16'd0);
        write_port(CFG_PORT_SECOND, 16'hFFFF);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd0, 16'd9999, 4'd5, "INVITE ", 9,
                0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_TCP, 16'd1, 16'hFFFF, 4'd5, "SIP/2.0", 9,
                0, 0, 0, 0);
        send_ip(IP_VERSION_4, 4'd5, PROTO_UDP, 16'd5060, 16'd5061, 4'd5, "INVITE ", 9,
                0, 0, 0, 0);
        settle();

        // Back to back with no idling on either side.
        random_phase(100, 16'd0, 16'hFFFF);
        settle();

        pa = 16'($urandom);
        pb = 16'($urandom);
        write_port(CFG_PORT_FIRST, pa);
        write_port(CFG_PORT_SECOND, pb);
        tx_idle_pct  = 20;
        rx_stall_pct = 25;
        hold_request = 1'b1;
        random_phase(100, pa, pb);
        settle();

        write_port(CFG_PORT_FIRST, 16'hFFFF);
        write_port(CFG_PORT_SECOND, 16'd0);
        tx_idle_pct  = 50;
        rx_stall_pct = 60;
        random_phase(100, 16'hFFFF, 16'd0);
        settle();

        write_port(CFG_PORT_FIRST, SIP_PORT_FIRST_RESET);
        write_port(CFG_PORT_SECOND, SIP_PORT_SECOND_RESET);
        tx_idle_pct  = 10;
        rx_stall_pct = 10;
        random_phase(100, SIP_PORT_FIRST_RESET, SIP_PORT_SECOND_RESET);
        settle();

        // Watch a little longer for stray result beats.
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
            $display("PASS sip_packet_classifier");
        else
            $display("FAIL sip_packet_classifier");
        $finish;
    end

endmodule

### sip_packet_classifier.f
hw/rtl/sipc_pkg.sv
hw/rtl/sip_packet_classifier.sv
hw/rtl/sipc_checker.sv
tb/sv/sip_packet_classifier_test.sv
